>>> sv/rfoa_pkg.sv
// ----------------------------------------------------------------------------
// rfoa_pkg: shared types and constants for the register file / operand address block
// Holds the operation codes, register numbers, reset values and packed item
// layouts used by the top level.
// ----------------------------------------------------------------------------
package rfoa_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_DECODE = 2'd2,
		OP_FLAGS  = 2'd3
	} op_t;

	localparam int NUM_REGS = 8;
	localparam int REG_W    = 16;

	// register numbers
	localparam logic [2:0] REG_BX = 3'd3;
	localparam logic [2:0] REG_SP = 3'd4;
	localparam logic [2:0] REG_BP = 3'd5;
	localparam logic [2:0] REG_SI = 3'd6;
	localparam logic [2:0] REG_DI = 3'd7;

	localparam logic [REG_W-1:0] SP_RESET = 16'hFFFF;

	// addressing modes
	localparam logic [1:0] MODE_NODISP = 2'd0;
	localparam logic [1:0] MODE_DISP8  = 2'd1;
	localparam logic [1:0] MODE_DISP16 = 2'd2;
	localparam logic [1:0] MODE_REG    = 2'd3;

	// r/m code that means a direct address in the no-displacement mode
	localparam logic [2:0] RM_DIRECT = 3'b110;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 48;

	// one input item (operation travels apart, on tuser)
	typedef struct packed {
		logic [15:0] flag_source;
		logic [7:0]  disp_high;
		logic [7:0]  disp_low;
		logic [2:0]  rm_field;
		logic [1:0]  mode_bits;
		logic [15:0] write_value;
		logic        wide;
		logic [2:0]  reg_index;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic        parity_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic [1:0]  displacement_bytes;
		logic [2:0]  operand_register;
		logic        operand_is_register;
		logic [15:0] effective_address;
		logic [15:0] read_value;
	} out_item_t;

	// stored status flags
	typedef struct packed {
		logic parity;
		logic zero;
		logic sign;
	} flags_t;

	function automatic logic even_parity(input logic [7:0] b);
		even_parity = ~(^b);
	endfunction

endpackage

>>> sv/register_file_and_operand_address_top.sv
// ----------------------------------------------------------------------------
// register_file_and_operand_address_top: 16-bit register file and operand address unit
// Eight general registers plus sign/zero/parity flags; each item writes or
// reads a register, decodes a mod/rm memory operand, or updates the flags.
// ----------------------------------------------------------------------------
//
// channel   dir  signals                      item
// --------  ---  ---------------------------  ------------------------------
// s_*       in   s_tvalid s_tready s_tdata    one operation request
//                s_tuser                      (tuser = operation code)
// m_*       out  m_tvalid m_tready m_tdata    one result per request
//
// Stages: an accepted item is held in the input stage, where the
// register file lookup, address add and flag logic run, then lands in the
// result register; one item is taken per cycle while m_tready does not stall the output.
// Register and flag writes commit when the item leaves the input stage, so
// a following item already sees them.
// Reset: arst_n clears all registers to zero except SP (0xFFFF), and the flags.
// Stalls: with m_tready low the result register holds and the input stage
// fills; s_tready drops only when both are occupied.

module register_file_and_operand_address_top
	import rfoa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] reg_index, [3] wide, [19:4] write_value, [21:20] mode_bits,
	// [24:22] rm_field, [32:25] disp_low, [40:33] disp_high,
	// [56:41] flag_source, [63:57] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [15:0] read_value, [31:16] effective_address, [32] operand_is_register,
	// [35:33] operand_register, [37:36] displacement_bytes, [38] sign_flag,
	// [39] zero_flag, [40] parity_flag, [47:41] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IN_ITEM_W  = $bits(in_item_t);
	localparam int OUT_ITEM_W = $bits(out_item_t);

	// input stage
	logic      valid_s1;
	in_item_t  item_s1;
	op_t       op_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	// architectural state
	logic [REG_W-1:0] regs_q [NUM_REGS];
	flags_t           flags_q;

	logic      adv;
	out_item_t res;
	flags_t    flags_new;

	logic [1:0]       r4;
	logic             hi_sel;
	logic [REG_W-1:0] reg_word;
	logic [REG_W-1:0] reg_byte_src;
	logic [REG_W-1:0] base;
	logic [REG_W-1:0] disp16;
	logic [REG_W-1:0] disp8_sx;

	// input stage advances whenever the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
			op_s1   <= op_t'(s_tuser);
		end
	end

	// ---- datapath for the item in the input stage ----
	assign r4           = item_s1.reg_index[1:0];
	assign hi_sel       = item_s1.reg_index[2];
	assign reg_word     = regs_q[item_s1.reg_index];
	assign reg_byte_src = regs_q[{1'b0, r4}];
	assign disp16       = {item_s1.disp_high, item_s1.disp_low};
	assign disp8_sx     = {{8{item_s1.disp_low[7]}}, item_s1.disp_low};

	// base/index combination, sum wraps at 16 bits
	always_comb begin
		case (item_s1.rm_field)
			3'd0:    base = regs_q[REG_BX] + regs_q[REG_SI];
			3'd1:    base = regs_q[REG_BX] + regs_q[REG_DI];
			3'd2:    base = regs_q[REG_BP] + regs_q[REG_SI];
			3'd3:    base = regs_q[REG_BP] + regs_q[REG_DI];
			3'd4:    base = regs_q[REG_SI];
			3'd5:    base = regs_q[REG_DI];
			3'd6:    base = regs_q[REG_BP];
			default: base = regs_q[REG_BX];
		endcase
	end

	always_comb begin
		flags_new = flags_q;
		if (op_s1 == OP_FLAGS) begin
			flags_new.sign   = item_s1.wide ? item_s1.flag_source[15]
			                                : item_s1.flag_source[7];
			flags_new.zero   = item_s1.wide ? (item_s1.flag_source == '0)
			                                : (item_s1.flag_source[7:0] == '0);
			flags_new.parity = even_parity(item_s1.flag_source[7:0]);
		end
	end

	always_comb begin
		res = '0;
		case (op_s1)
			OP_READ: begin
				if (item_s1.wide) begin
					res.read_value = reg_word;
				end else if (hi_sel) begin
					res.read_value = {8'h00, reg_byte_src[15:8]};
				end else begin
					res.read_value = {8'h00, reg_byte_src[7:0]};
				end
			end
			OP_DECODE: begin
				case (item_s1.mode_bits)
					MODE_NODISP: begin
						if (item_s1.rm_field == RM_DIRECT) begin
							res.effective_address  = disp16;
							res.displacement_bytes = 2'd2;
						end else begin
							res.effective_address = base;
						end
					end
					MODE_DISP8: begin
						res.effective_address  = base + disp8_sx;
						res.displacement_bytes = 2'd1;
					end
					MODE_DISP16: begin
						res.effective_address  = base + disp16;
						res.displacement_bytes = 2'd2;
					end
					default: begin
						res.operand_is_register = 1'b1;
						res.operand_register    = item_s1.rm_field;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.sign_flag   = flags_new.sign;
		res.zero_flag   = flags_new.zero;
		res.parity_flag = flags_new.parity;
	end

	// ---- state commit, once per item as it leaves the input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= (i == int'(REG_SP)) ? SP_RESET : '0;
			end
			flags_q <= '0;
		end else if (adv) begin
			flags_q <= flags_new;
			if (op_s1 == OP_WRITE) begin
				if (item_s1.wide) begin
					regs_q[item_s1.reg_index] <= item_s1.write_value;
				end else if (hi_sel) begin
					regs_q[{1'b0, r4}] <= {item_s1.write_value[7:0], reg_byte_src[7:0]};
				end else begin
					regs_q[{1'b0, r4}] <= {reg_byte_src[15:8], item_s1.write_value[7:0]};
				end
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_ITEM_W){1'b0}}, out_q};

`ifndef SYNTHESIS
	// register operand results never carry an address or displacement
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.operand_is_register) |->
			(out_q.effective_address == '0 && out_q.displacement_bytes == 2'd0))
		else $error("register operand with address or displacement");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.displacement_bytes != 2'd3))
		else $error("displacement byte count out of range");

	// flags move only on a flag update leaving the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && op_s1 == OP_FLAGS) |=> $stable(flags_q))
		else $error("flags changed without a flag update");

	// SP changes only on a register write
	assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && op_s1 == OP_WRITE) |=> $stable(regs_q[REG_SP]))
		else $error("SP changed without a register write");

	// an empty input stage always takes a new item
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");
`endif

endmodule

>>> dv/register_file_and_operand_address_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_file_and_operand_address_top_test: stream test of the register file block
// Sends register writes and reads, mod/rm operand decodes and flag updates.
// Each accepted item is run through a local model of the registers and
// flags, and every result item is compared field by field, in order. The
// sender gaps and the receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------

module register_file_and_operand_address_top_test;
	import rfoa_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [2:0] reg_index, [3] wide, [19:4] write_value, [21:20] mode_bits,
	// [24:22] rm_field, [32:25] disp_low, [40:33] disp_high,
	// [56:41] flag_source, [63:57] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// [1:0] operation
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [15:0] read_value, [31:16] effective_address, [32] operand_is_register,
	// [35:33] operand_register, [37:36] displacement_bytes, [38] sign_flag,
	// [39] zero_flag, [40] parity_flag, [47:41] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	register_file_and_operand_address_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// model state: general registers and stored flags
	logic [REG_W-1:0] gpr_model [NUM_REGS];
	flags_t           flags_model;

	out_item_t pending_results[$];
	int        err_count = 0;
	int        send_idle_pct = 0;   // chance per cycle that the sender holds off
	int        recv_stall_pct = 0;  // chance per cycle that m_tready is low

	// base/index sum of a memory operand, wrapped to 16 bits
	function automatic logic [15:0] operand_base(input logic [2:0] rm);
		case (rm)
			3'd0: operand_base = gpr_model[REG_BX] + gpr_model[REG_SI];
			3'd1: operand_base = gpr_model[REG_BX] + gpr_model[REG_DI];
			3'd2: operand_base = gpr_model[REG_BP] + gpr_model[REG_SI];
			3'd3: operand_base = gpr_model[REG_BP] + gpr_model[REG_DI];
			3'd4: operand_base = gpr_model[REG_SI];
			3'd5: operand_base = gpr_model[REG_DI];
			3'd6: operand_base = gpr_model[REG_BP];
			default: operand_base = gpr_model[REG_BX];
		endcase
	endfunction

	// applies one item to the model state and returns the result it causes
	function automatic out_item_t apply_operation(input op_t op, input in_item_t it);
		out_item_t  res;
		logic [2:0] byte_reg;
		logic [7:0] src_lo;
		res = '0;
		byte_reg = {1'b0, it.reg_index[1:0]};
		src_lo = it.flag_source[7:0];
		case (op)
			OP_WRITE: begin
				if (it.wide)
					gpr_model[it.reg_index] = it.write_value;
				else if (it.reg_index[2])
					gpr_model[byte_reg][15:8] = it.write_value[7:0];
				else
					gpr_model[byte_reg][7:0] = it.write_value[7:0];
			end
			OP_READ: begin
				if (it.wide)
					res.read_value = gpr_model[it.reg_index];
				else if (it.reg_index[2])
					res.read_value = {8'h00, gpr_model[byte_reg][15:8]};
				else
					res.read_value = {8'h00, gpr_model[byte_reg][7:0]};
			end
			OP_DECODE: begin
				if (it.mode_bits == MODE_NODISP && it.rm_field == RM_DIRECT) begin
					res.effective_address = {it.disp_high, it.disp_low};
					res.displacement_bytes = 2'd2;
				end else if (it.mode_bits == MODE_NODISP) begin
					res.effective_address = operand_base(it.rm_field);
				end else if (it.mode_bits == MODE_DISP8) begin
					res.effective_address = operand_base(it.rm_field)
						+ {{8{it.disp_low[7]}}, it.disp_low};
					res.displacement_bytes = 2'd1;
				end else if (it.mode_bits == MODE_DISP16) begin
					res.effective_address = operand_base(it.rm_field)
						+ {it.disp_high, it.disp_low};
					res.displacement_bytes = 2'd2;
				end else begin
					res.operand_is_register = 1'b1;
					res.operand_register = it.rm_field;
				end
			end
			default: begin
				flags_model.sign = it.wide ? it.flag_source[15] : it.flag_source[7];
				flags_model.zero = it.wide ? (it.flag_source == 16'h0000) : (src_lo == 8'h00);
				flags_model.parity = ~^src_lo;
			end
		endcase
		res.sign_flag = flags_model.sign;
		res.zero_flag = flags_model.zero;
		res.parity_flag = flags_model.parity;
		return res;
	endfunction

	// one item onto the slave side; the model runs at the accepting edge
	task automatic send_item(input op_t op, input in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, it};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_operation(op, it));
	endtask

	task automatic send_fields(input op_t op, input logic [2:0] rx, input logic wd,
			input logic [15:0] wv, input logic [1:0] md, input logic [2:0] rm,
			input logic [7:0] dlo, input logic [7:0] dhi, input logic [15:0] src);
		in_item_t it;
		it.reg_index = rx;
		it.wide = wd;
		it.write_value = wv;
		it.mode_bits = md;
		it.rm_field = rm;
		it.disp_low = dlo;
		it.disp_high = dhi;
		it.flag_source = src;
		send_item(op, it);
	endtask

	// receiver stalls, redrawn every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			err_count++;
		end
	endtask

	// result checker: compares each accepted result with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(out_item_t)-1:0];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_value", want.read_value, got.read_value);
				check_field("effective_address", want.effective_address,
					got.effective_address);
				check_field("operand_is_register", 16'(want.operand_is_register),
					16'(got.operand_is_register));
				check_field("operand_register", 16'(want.operand_register),
					16'(got.operand_register));
				check_field("displacement_bytes", 16'(want.displacement_bytes),
					16'(got.displacement_bytes));
				check_field("sign_flag", 16'(want.sign_flag), 16'(got.sign_flag));
				check_field("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
				check_field("parity_flag", 16'(want.parity_flag), 16'(got.parity_flag));
			end
		end
	end

	// registers right after reset: SP starts all ones, register 0 zero
	task automatic test_reset_state();
		send_fields(OP_READ, REG_SP, 1'b1, '0, '0, '0, '0, '0, '0);
		send_fields(OP_READ, 3'd0, 1'b1, '0, '0, '0, '0, '0, '0);
	endtask

	// word, low byte and high byte writes, then reads of each width
	task automatic test_register_access();
		send_fields(OP_WRITE, REG_BX, 1'b1, 16'hFFFF, '0, '0, '0, '0, '0);
		send_fields(OP_WRITE, 3'd1, 1'b0, 16'h12AB, '0, '0, '0, '0, '0);
		// high byte of CX takes the low byte of the value
		send_fields(OP_WRITE, 3'd5, 1'b0, 16'h1234, '0, '0, '0, '0, '0);
		send_fields(OP_READ, 3'd1, 1'b1, '0, '0, '0, '0, '0, '0);
		send_fields(OP_READ, 3'd5, 1'b0, '0, '0, '0, '0, '0, '0);
		send_fields(OP_READ, 3'd1, 1'b0, '0, '0, '0, '0, '0, '0);
	endtask

	// every addressing mode, the direct address, a negative disp8, a wrapping sum
	task automatic test_operand_decode();
		send_fields(OP_DECODE, '0, 1'b0, '0, MODE_NODISP, RM_DIRECT, 8'hCD, 8'hAB, '0);
		send_fields(OP_DECODE, '0, 1'b0, '0, MODE_NODISP, 3'd0, 8'hFF, 8'hFF, '0);
		send_fields(OP_DECODE, '0, 1'b0, '0, MODE_DISP8, 3'd7, 8'h80, 8'h00, '0);
		send_fields(OP_DECODE, '0, 1'b0, '0, MODE_DISP16, 3'd7, 8'hFF, 8'hFF, '0);
		send_fields(OP_DECODE, '0, 1'b0, '0, MODE_REG, 3'd7, 8'hFF, 8'hFF, '0);
	endtask

	// sign and zero at both widths, even and odd parity
	task automatic test_flag_update();
		send_fields(OP_FLAGS, '0, 1'b1, '0, '0, '0, '0, '0, 16'h8000);
		send_fields(OP_FLAGS, '0, 1'b0, '0, '0, '0, '0, '0, 16'hFF00);
		send_fields(OP_FLAGS, '0, 1'b1, '0, '0, '0, '0, '0, 16'h0000);
		send_fields(OP_FLAGS, '0, 1'b0, '0, '0, '0, '0, '0, 16'h0080);
		send_fields(OP_FLAGS, '0, 1'b1, '0, '0, '0, '0, '0, 16'h0001);
	endtask

	// random items of every kind; a few flag sources with a zero low byte
	task automatic test_random_traffic(input int count);
		in_item_t    it;
		op_t         op;
		logic [63:0] rnd;
		for (int n = 0; n < count; n++) begin
			rnd = {$urandom, $urandom};
			it = rnd[$bits(in_item_t)-1:0];
			op = op_t'($urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0)
				it.flag_source[7:0] = 8'h00;
			if ($urandom_range(0, 15) == 0)
				it.flag_source = 16'h0000;
			send_item(op, it);
		end
	endtask

	initial begin
		for (int r = 0; r < NUM_REGS; r++)
			gpr_model[r] = '0;
		gpr_model[REG_SP] = SP_RESET;
		flags_model = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_register_access();
		test_operand_decode();
		test_flag_update();

		// gap phases: none, sender only, receiver only, both
		test_random_traffic(220);
		send_idle_pct = 57;
		test_random_traffic(220);
		send_idle_pct = 0;
		recv_stall_pct = 57;
		test_random_traffic(220);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		test_random_traffic(220);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
